### sv/tfpc_pkg.sv
`default_nettype none
// Shared types, frame constants and CRC-8 (poly 0x07) helpers for the
// thermal frame check decoder. No dependencies.
package tfpc_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int IDX_W       = 6;
    localparam logic [IDX_W-1:0] FRAME_LAST  = IDX_W'(FRAME_BYTES - 1);
    localparam logic [IDX_W-1:0] FRAME_COUNT = IDX_W'(FRAME_BYTES);

    localparam logic [IDX_W-1:0] IDX_AMB_LO = IDX_W'(0);
    localparam logic [IDX_W-1:0] IDX_AMB_HI = IDX_W'(1);
    localparam logic [IDX_W-1:0] IDX_PIX_LO = IDX_W'(2);
    localparam logic [IDX_W-1:0] IDX_PIX_HI = IDX_W'(3);

    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [6:0] ADDR_RESET = 7'd10;

    typedef struct packed {
        logic       valid;
        logic       start;
        logic [7:0] data;
    } item_t;

    typedef struct packed {
        logic signed [15:0] ambient_tenths;
        logic signed [15:0] pixel_tenths;
        logic               check_passed;
    } result_t;

    function automatic logic [7:0] crc8_byte(input logic [7:0] v);
        logic [7:0] c;
        c = v;
        for (int k = 0; k < 8; k++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC of the read address byte
    function automatic logic [7:0] addr_seed(input logic [6:0] addr);
        return crc8_byte({addr, 1'b1});
    endfunction

    localparam logic [7:0] SEED_RESET = addr_seed(ADDR_RESET);

endpackage
`default_nettype wire

### sv/tfpc_input_stage.sv
`default_nettype none
// Input register for the byte stream: holds one transaction until the
// decode stage consumes it. Depends on tfpc_pkg.
module tfpc_input_stage
    import tfpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       in_start,
    input  wire logic [7:0] in_data,
    input  wire logic       consume,
    output item_t           item
);

    logic       vld_reg;
    logic       start_reg;
    logic [7:0] data_reg;

    assign in_ready = !vld_reg || consume;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (consume)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            start_reg <= in_start;
            data_reg  <= in_data;
        end
    end

    assign item = '{valid: vld_reg, start: start_reg, data: data_reg};

endmodule
`default_nettype wire

### sv/tfpc_decode.sv
`default_nettype none
// Frame tracking, CRC-8 update, word assembly and result register.
// Depends on tfpc_pkg.
module tfpc_decode
    import tfpc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_addr,
    input  wire item_t      item,
    output logic            consume,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         result
);

    logic [7:0]       seed_reg;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [7:0]       crc_reg, crc_next;
    logic [15:0]      amb_reg, amb_next;
    logic [15:0]      pix_reg, pix_next;
    logic             out_vld_reg;
    result_t          res_reg, res_next;
    logic             emit;

    logic [IDX_W-1:0] idx_eff;
    logic [7:0]       crc_eff;

    assign consume = item.valid && (!out_vld_reg || out_ready);

    always_comb
    begin
        idx_eff  = item.start ? '0 : idx_reg;
        crc_eff  = item.start ? seed_reg : crc_reg;
        idx_next = idx_eff;
        crc_next = crc_eff;
        amb_next = amb_reg;
        pix_next = pix_reg;
        emit     = 1'b0;
        res_next = '{ambient_tenths: amb_reg, pixel_tenths: pix_reg,
                     check_passed: (crc_eff == item.data)};
        if (idx_eff == FRAME_LAST)
        begin
            emit     = 1'b1;
            idx_next = FRAME_COUNT;
        end
        else if (idx_eff < FRAME_LAST)
        begin
            crc_next = crc8_byte(crc_eff ^ item.data);
            idx_next = idx_eff + 1'b1;
            case (idx_eff)
                IDX_AMB_LO: amb_next = {amb_reg[15:8], item.data};
                IDX_AMB_HI: amb_next = {item.data, amb_reg[7:0]};
                IDX_PIX_LO: pix_next = {pix_reg[15:8], item.data};
                IDX_PIX_HI: pix_next = {item.data, pix_reg[7:0]};
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= SEED_RESET;
            idx_reg     <= '0;
            crc_reg     <= '0;
            amb_reg     <= '0;
            pix_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                seed_reg <= addr_seed(cfg_addr);
            end
            if (consume)
            begin
                idx_reg <= idx_next;
                crc_reg <= crc_next;
                amb_reg <= amb_next;
                pix_reg <= pix_next;
            end
            if (consume && emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (consume && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign result    = res_reg;

endmodule
`default_nettype wire

### sv/thermal_frame_pec_check_decode.sv
`default_nettype none
// Top level of the thermal sensor frame decoder with packet error check.
// Depends on tfpc_pkg, tfpc_input_stage and tfpc_decode.
//
//  channel   dir  signals                         content
//  s_axis    in   tvalid/tready/tdata[7:0]/tuser  frame bytes, tuser = frame start
//  m_axis    out  tvalid/tready/tdata[39:0]       ambient, pixel, check flag
//  cfg       in   cfg_valid/cfg_ready/cfg_data    device address, always ready
//
// One byte per cycle sustained while m_axis takes results; the closing byte of a
// frame passes the input register, then decode into the result register.
// Reset clears frame index and CRC and restores the address seed.
// A result waiting on m_axis stalls decode; one more byte is still taken into
// the input register.
module thermal_frame_pec_check_decode
    import tfpc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  wire logic        s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [15:0] ambient_tenths,
                                             // [31:16] pixel_tenths,
                                             // [32] check_passed, [39:33] zero
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data        // [6:0] device_address
);

    item_t   item;
    logic    consume;
    result_t result;

    assign cfg_ready = 1'b1;

    tfpc_input_stage u_input (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_start (s_axis_tuser),
        .in_data  (s_axis_tdata),
        .consume  (consume),
        .item     (item)
    );

    tfpc_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_addr  (cfg_data),
        .item      (item),
        .consume   (consume),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {7'd0, result.check_passed,
                           result.pixel_tenths, result.ambient_tenths};

    a_consume_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        consume |-> item.valid)
        else $error("decode consumed an empty input register");

    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> item.valid)
        else $error("input stalled with empty input register");

    a_no_consume_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !consume)
        else $error("decode advanced while result held");

    a_result_from_consume: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(consume))
        else $error("result appeared without a consumed byte");

endmodule
`default_nettype wire

### bench/tb_thermal_frame_pec_check_decode.sv
`timescale 1ns / 1ps
// Testbench for thermal_frame_pec_check_decode: directed frames, then random frames
// with good, bad and broken checks, checked against a local frame decoder.
// Depends on tfpc_pkg and the RTL of the block.
module tb_thermal_frame_pec_check_decode;
    import tfpc_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 6;

    typedef enum logic [1:0] {PEC_RAW, PEC_GOOD, PEC_BAD} pec_mode_e;

    typedef struct {
        logic       st;
        logic [7:0] b;
        pec_mode_e  mode;
        bit         typed;
        result_t    res;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = 7'd0;

    // decoder shadow state
    logic [6:0]  dev_addr;
    logic [5:0]  frm_idx;
    logic [7:0]  frm_crc;
    logic [15:0] amb_word;
    logic [15:0] pix_word;

    result_t     frame_results[$];
    stim_row_t   dir_rows[23];
    bit          gaps_on = 1'b1;
    int          err_cnt = 0;
    int          bytes_used = 0;
    int          frames_seen = 0;
    int          bad_pec_seen = 0;
    int          addr_settings = 1;
    int          stall_cnt = 0;

    thermal_frame_pec_check_decode u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [7:0] crc8_fold(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
        return r;
    endfunction

    // one frame byte; returns 1 when the byte closes a frame
    function automatic bit decode_frame_byte(input logic st, input logic [7:0] b,
                                             output result_t r);
        r = '0;
        if (st)
        begin
            frm_idx = '0;
            frm_crc = crc8_fold({dev_addr, 1'b1});
        end
        if (frm_idx >= 6'(FRAME_BYTES))
            return 1'b0;
        if (frm_idx == 6'(FRAME_BYTES - 1))
        begin
            r.ambient_tenths = amb_word;
            r.pixel_tenths   = pix_word;
            r.check_passed   = (frm_crc == b);
            frm_idx = frm_idx + 6'd1;
            return 1'b1;
        end
        frm_crc = crc8_fold(frm_crc ^ b);
        case (frm_idx)
            6'd0: amb_word[7:0]  = b;
            6'd1: amb_word[15:8] = b;
            6'd2: pix_word[7:0]  = b;
            6'd3: pix_word[15:8] = b;
            default: ;
        endcase
        frm_idx = frm_idx + 6'd1;
        return 1'b0;
    endfunction

    function automatic stim_row_t mk_row(input logic st, input logic [7:0] b,
                                         input pec_mode_e mode, input bit typed,
                                         input logic [15:0] amb, input logic [15:0] pix,
                                         input logic pass);
        stim_row_t row;
        row.st = st;
        row.b = b;
        row.mode = mode;
        row.typed = typed;
        row.res.ambient_tenths = amb;
        row.res.pixel_tenths = pix;
        row.res.check_passed = pass;
        return row;
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 15))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h7F;
            3: return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    task automatic send_byte(input logic st, input logic [7:0] b, input pec_mode_e mode,
                             input bit typed, input result_t typed_res);
        logic [7:0] d;
        result_t    r;
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        case (mode)
            PEC_GOOD: d = frm_crc;
            PEC_BAD:  d = frm_crc ^ 8'hFF;
            default:  d = b;
        endcase
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= st;
        do @(posedge clk); while (!s_axis_tready);
        if (st || frm_idx < 6'(FRAME_BYTES))
            bytes_used++;
        if (decode_frame_byte(st, d, r))
        begin
            frame_results.push_back(typed ? typed_res : r);
            frames_seen++;
        end
    endtask

    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (frame_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_addr(input logic [6:0] a);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        dev_addr = a;
        addr_settings++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_frame();
        int        kind;
        int        n;
        pec_mode_e m;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            send_byte(1'b1, rand_byte(), PEC_RAW, 1'b0, '0);
            for (int k = 1; k < FRAME_BYTES - 1; k++)
                send_byte(1'b0, rand_byte(), PEC_RAW, 1'b0, '0);
            n = $urandom_range(0, 9);
            if (n < 7)
                m = PEC_GOOD;
            else if (n < 9)
                m = PEC_BAD;
            else
                m = PEC_RAW;
            send_byte(1'b0, rand_byte(), m, 1'b0, '0);
        end
        else if (kind < 80)
        begin
            // truncated frame, abandoned by the next start
            send_byte(1'b1, rand_byte(), PEC_RAW, 1'b0, '0);
            n = $urandom_range(0, FRAME_BYTES - 3);
            repeat (n) send_byte(1'b0, rand_byte(), PEC_RAW, 1'b0, '0);
        end
        else if (kind < 90)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(1'b0, rand_byte(), PEC_RAW, 1'b0, '0);
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(($urandom_range(0, 3) == 0), 8'($urandom), PEC_RAW,
                                 1'b0, '0);
        end
    endtask

    always @(negedge clk)
        m_axis_tready <= !(gaps_on && $urandom_range(0, 99) < 11);

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.ambient_tenths = m_axis_tdata[15:0];
            got.pixel_tenths   = m_axis_tdata[31:16];
            got.check_passed   = m_axis_tdata[32];
            if (!got.check_passed)
                bad_pec_seen++;
            if (frame_results.size() == 0)
                flag_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            else
            begin
                want = frame_results.pop_front();
                if (got.ambient_tenths !== want.ambient_tenths)
                    flag_mismatch($sformatf("ambient_tenths got %h want %h",
                                            got.ambient_tenths, want.ambient_tenths));
                if (got.pixel_tenths !== want.pixel_tenths)
                    flag_mismatch($sformatf("pixel_tenths got %h want %h",
                                            got.pixel_tenths, want.pixel_tenths));
                if (got.check_passed !== want.check_passed)
                    flag_mismatch($sformatf("check_passed got %b want %b",
                                            got.check_passed, want.check_passed));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        int        target;
        bit        paused;
        logic [6:0] a;
        dev_addr = ADDR_RESET;
        frm_idx  = '0;
        frm_crc  = '0;
        amb_word = '0;
        pix_word = '0;

        // bytes before any start decode as a frame from reset with a zero CRC
        dir_rows[0]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[1]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[2]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[3]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[4]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b1, 16'h0000, 16'h0000, 1'b1);
        // trailing byte after a complete frame is ignored
        dir_rows[5]  = mk_row(1'b0, 8'hFF, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[6]  = mk_row(1'b1, 8'hFF, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[7]  = mk_row(1'b0, 8'h7F, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[8]  = mk_row(1'b0, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[9]  = mk_row(1'b0, 8'h80, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[10] = mk_row(1'b0, 8'h00, PEC_GOOD, 1'b1, 16'h7FFF, 16'h8000, 1'b1);
        dir_rows[11] = mk_row(1'b1, 8'h00, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[12] = mk_row(1'b0, 8'h80, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[13] = mk_row(1'b0, 8'hFF, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[14] = mk_row(1'b0, 8'h7F, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[15] = mk_row(1'b0, 8'h00, PEC_BAD,  1'b1, 16'h8000, 16'h7FFF, 1'b0);
        // start mid-frame abandons the frame
        dir_rows[16] = mk_row(1'b1, 8'hAA, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[17] = mk_row(1'b0, 8'h55, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[18] = mk_row(1'b1, 8'h12, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[19] = mk_row(1'b0, 8'h34, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[20] = mk_row(1'b0, 8'h56, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[21] = mk_row(1'b0, 8'h78, PEC_RAW,  1'b0, 16'h0, 16'h0, 1'b0);
        dir_rows[22] = mk_row(1'b0, 8'h00, PEC_GOOD, 1'b0, 16'h0, 16'h0, 1'b0);

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_byte(dir_rows[i].st, dir_rows[i].b, dir_rows[i].mode,
                      dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                case (ph)
                    1: a = 7'd0;
                    2: a = 7'd127;
                    default: a = 7'($urandom_range(0, 127));
                endcase
                write_addr(a);
            end
            gaps_on = (ph != 2);
            target = bytes_used + 250;
            paused = 1'b0;
            while (bytes_used < target)
            begin
                random_frame();
                if (ph == 3 && !paused && bytes_used >= target - 125)
                begin
                    drain();
                    paused = 1'b1;
                end
            end
        end
        gaps_on = 1'b1;
        drain();

        $display("summary: %0d frame bytes decoded, %0d frames closed (%0d failed the check)",
                 bytes_used, frames_seen, bad_pec_seen);
        $display("summary: %0d device address settings, %0d mismatches", addr_settings,
                 err_cnt);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

### files.f
sv/tfpc_pkg.sv
sv/tfpc_input_stage.sv
sv/tfpc_decode.sv
sv/thermal_frame_pec_check_decode.sv
bench/tb_thermal_frame_pec_check_decode.sv
